// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CSB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked on every rising edge out of reset
`define CSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg
// types and constants for the cursor sequence buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csb_pkg;

  // storage geometry
  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // field widths on the stream ports
  localparam int REQ_W       = 3;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 6;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // request codes; the two unused codes act as status only
  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 3'd0,
    REQ_ADVANCE = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_ATTACH  = 3'd3,
    REQ_REMOVE  = 3'd4,
    REQ_STATUS  = 3'd5
  } csb_req_t;

  // what every cell of the row does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] word;
  } cell_cmd_t;

  // controller status towards the output register
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cursor;
    logic             err;
  } csb_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } csb_state_t;

endpackage

// ===== hdl/csb_cell.sv =====
// ----------------------------------------------------------------------------
// csb_cell
// one storage cell of the row: hold, load, or take a neighbour's word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csb_cell
  import csb_pkg::*;
(
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [IDX_W-1:0]      cell_idx,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  output logic [DATA_WIDTH-1:0] word_q
);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  // open: cells above the gap take from below, the gap cell loads the word
  // close: cells from the gap upward take from above
  always_comb begin
    word_nxt = word_r;
    unique case (cmd.op)
      CELL_OPEN: begin
        if (cell_idx > cmd.pos) begin
          word_nxt = left_word;
        end else if (cell_idx == cmd.pos) begin
          word_nxt = cmd.word;
        end
      end
      CELL_CLOSE: begin
        if (cell_idx >= cmd.pos) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

// ===== hdl/csb_ctrl.sv =====
// ----------------------------------------------------------------------------
// csb_ctrl
// request sequencer: count, cursor, cell row commands and handshakes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csb_ctrl
  import csb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [REQ_W-1:0] req_type,
  input  logic [VAL_W-1:0] entry_value,
  output logic             out_tvalid,
  input  logic             out_tready,
  output cell_cmd_t        cmd,
  output csb_stat_t        stat
);

  csb_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cursor_r, cursor_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             has_cur;
  logic             full;
  logic [CNT_W-1:0] cur_inc;
  logic             load;

  assign has_cur = cursor_r < count_r;
  assign full    = count_r == CNT_W'(CAPACITY);
  assign cur_inc = cursor_r + CNT_W'(1);

  // next state, row command and handshakes
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    in_tready     = 1'b0;
    load          = 1'b0;
    cmd.op        = CELL_HOLD;
    cmd.pos       = '0;
    cmd.word      = DATA_WIDTH'(entry_value);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (in_tvalid && in_tready) begin
          err_nxt   = 1'b0;
          state_nxt = ST_REPORT;
          unique case (csb_req_t'(req_type))
            REQ_START: begin
              cursor_nxt = '0;
            end
            REQ_ADVANCE: begin
              if (has_cur) begin
                cursor_nxt = cur_inc;
              end
            end
            REQ_INSERT: begin
              if (full) begin
                err_nxt = 1'b1;
              end else begin
                cmd.op     = CELL_OPEN;
                cmd.pos    = has_cur ? cursor_r[IDX_W-1:0] : '0;
                cursor_nxt = has_cur ? cursor_r : '0;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            REQ_ATTACH: begin
              if (full) begin
                err_nxt = 1'b1;
              end else begin
                cmd.op     = CELL_OPEN;
                cmd.pos    = has_cur ? cur_inc[IDX_W-1:0] : count_r[IDX_W-1:0];
                cursor_nxt = has_cur ? cur_inc : count_r;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              if (!has_cur) begin
                err_nxt = 1'b1;
              end else begin
                cmd.op    = CELL_CLOSE;
                cmd.pos   = cursor_r[IDX_W-1:0];
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REPORT: begin
        // row has settled; capture the result
        load          = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign stat.load   = load;
  assign stat.count  = count_r;
  assign stat.cursor = cursor_r;
  assign stat.err    = err_r;

endmodule

// ===== hdl/cursor_sequence_buffer_top.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_top
// ordered word store with a cursor, built as a row of shifting cells
// ----------------------------------------------------------------------------
// Each request runs in two steps: on acceptance the controller updates count
// and cursor and the whole cell row shifts or loads in parallel (insert,
// attach and remove all finish in this step); in the report state the word
// at the cursor is read out of the row into the output register. The next
// request is accepted in the cycle the result transaction completes.
// Entries start undefined; only entries below the count are ever reported.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cursor_sequence_buffer_top
  import csb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] req_type, [34:3] entry_value, [39:35] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] current_value, [32] has_current, [38:33] entry_count,
  // [44:39] cursor_pos, [45] req_error, [47:46] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cell_cmd_t             cmd;
  csb_stat_t             stat;
  logic [DATA_WIDTH-1:0] cells_q [CAPACITY];

  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_has;
  logic [DATA_WIDTH-1:0] rd_word;

  logic [VAL_W-1:0]      current_value_r;
  logic                  has_current_r;
  logic [POS_W-1:0]      entry_count_r;
  logic [POS_W-1:0]      cursor_pos_r;
  logic                  req_error_r;

  // sequencer
  csb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .req_type    (in_tdata[REQ_W-1:0]),
    .entry_value (in_tdata[REQ_W+VAL_W-1:REQ_W]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // row of cells, each linked to the neighbours it has; cell 0 takes the new word from the left
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = cmd.word;
    end else begin : g_mid_l
      assign left_w = cells_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cells_q[i];
    end else begin : g_mid_r
      assign right_w = cells_q[i+1];
    end

    csb_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (IDX_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .word_q     (cells_q[i])
    );
  end

  // read the word at the cursor
  assign rd_idx  = stat.cursor[IDX_W-1:0];
  assign rd_has  = stat.cursor < stat.count;
  assign rd_word = rd_has ? cells_q[rd_idx] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (stat.load) begin
      current_value_r <= VAL_W'(rd_word);
      has_current_r   <= rd_has;
      entry_count_r   <= POS_W'(stat.count);
      cursor_pos_r    <= POS_W'(stat.cursor);
      req_error_r     <= stat.err;
    end
  end

  assign out_tdata = {2'b00, req_error_r, cursor_pos_r, entry_count_r,
                      has_current_r, current_value_r};

  // count and cursor stay within the store
  `CSB_ASSERT_NOW(a_count_in_range, 1'b1, stat.count <= CNT_W'(CAPACITY))
  `CSB_ASSERT_NOW(a_cursor_in_range, 1'b1, stat.cursor <= stat.count)
  // a reported current entry lies below the reported count
  `CSB_ASSERT_NOW(a_out_consistent, out_tvalid && has_current_r,
                  cursor_pos_r < entry_count_r)
  // one request at a time: no transaction right after an accepted one
  `CSB_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

endmodule
